// File: rtl/core/tdd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdd_pkg
// Shared types and constants of the tail-delimiter deframer.
// ----------------------------------------------------------------------------
package tdd_pkg;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELIM      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DELIM_LEN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN    = 2'd3;

    // input action codes
    localparam logic ACT_DATA  = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic step;   // take the input beat
        logic load;   // move store byte into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic emit;       // input beat closes a non-empty message
        logic out_free;   // output register can take a byte
        logic last_byte;  // byte being read is the final one
    } t_dp_status;

endpackage

// File: rtl/core/tdd_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdd_in_if
// Input channel: one action/byte beat per handshake.
// ----------------------------------------------------------------------------
interface tdd_in_if;
    logic                       valid;
    logic                       ready;
    logic                       action;
    logic [tdd_pkg::BYTE_W-1:0] data_byte;

    modport source (output valid, output action, output data_byte, input ready);
    modport sink   (input valid, input action, input data_byte, output ready);
endinterface

// File: rtl/core/tdd_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdd_out_if
// Output channel: one message byte per handshake.
// ----------------------------------------------------------------------------
interface tdd_out_if;
    logic                       valid;
    logic                       ready;
    logic [tdd_pkg::BYTE_W-1:0] out_byte;
    logic                       last;
    logic [tdd_pkg::LEN_W-1:0]  message_length;

    modport source (output valid, output out_byte, output last, output message_length,
                    input ready);
    modport sink   (input valid, input out_byte, input last, input message_length,
                    output ready);
endinterface

// File: rtl/core/tdd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tdd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/tdd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdd_ctrl
// Controller: takes input beats while idle, then streams a message out.
// ----------------------------------------------------------------------------
module tdd_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  tdd_pkg::t_dp_status   i_status,
    output logic                  o_in_ready,
    output tdd_pkg::t_dp_cmd      o_cmd
);

    tdd_pkg::t_state r_state;
    tdd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tdd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            tdd_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.step = 1'b1;
                    if (i_status.emit) begin
                        n_state = tdd_pkg::ST_EMIT;
                    end
                end
            end
            tdd_pkg::ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    if (i_status.last_byte) begin
                        n_state = tdd_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = tdd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/tdd_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdd_dp
// Datapath: config registers, message store, delimiter match, output register.
// ----------------------------------------------------------------------------
module tdd_dp #(
    parameter int MAX_LEN   = 64,
    parameter int DELIM_MAX = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [tdd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tdd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_action,
    input  logic [tdd_pkg::BYTE_W-1:0]         i_data_byte,
    input  tdd_pkg::t_dp_cmd                   i_cmd,
    output tdd_pkg::t_dp_status                o_status,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [tdd_pkg::BYTE_W-1:0]         o_out_byte,
    output logic                               o_last,
    output logic [tdd_pkg::LEN_W-1:0]          o_message_length
);

    localparam int AW   = $clog2(MAX_LEN);
    localparam int CW   = $clog2(MAX_LEN + 1);
    localparam int RW   = 8 * DELIM_MAX;
    localparam int DCAP = (DELIM_MAX < MAX_LEN - 1) ? DELIM_MAX : MAX_LEN - 1;

    // circular index wrap, sum known to stay below twice the depth
    function automatic logic [AW-1:0] wrap_addr(input logic [AW:0] s);
        logic [AW:0] lim;
        lim = (AW+1)'(MAX_LEN);
        return (s >= lim) ? AW'(s - lim) : AW'(s);
    endfunction

    // configuration
    logic                       r_enable;
    logic [31:0]                r_delim;
    logic [2:0]                 r_dlen;
    logic [tdd_pkg::LEN_W-1:0]  r_maxlen;

    // buffer state
    logic [AW-1:0] r_sp, n_sp;
    logic [CW-1:0] r_fill, n_fill;
    logic [RW-1:0] r_recent, n_recent;

    // emission
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_len, n_len;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_out_valid, n_out_valid;
    logic [tdd_pkg::BYTE_W-1:0] r_out_byte;
    logic          r_out_last;
    logic [tdd_pkg::LEN_W-1:0]  r_out_len;

    logic [CW-1:0] eff_l, m_cap, eff_m, fill_c, fill_new;
    logic [AW-1:0] waddr, discard_sp;
    logic [RW-1:0] recent_new, delim_ext;
    logic [DCAP:1] tail_hit;
    logic          sel_hit, match, take_byte, do_clear, last_byte;
    logic [tdd_pkg::BYTE_W-1:0] rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
            r_delim  <= '0;
            r_dlen   <= 3'd1;
            r_maxlen <= 7'd64;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                tdd_pkg::CFG_ENABLE:    r_enable <= i_cfg_data[0];
                tdd_pkg::CFG_DELIM:     r_delim  <= i_cfg_data[31:0];
                tdd_pkg::CFG_DELIM_LEN: r_dlen   <= i_cfg_data[2:0];
                tdd_pkg::CFG_MAX_LEN:   r_maxlen <= i_cfg_data[tdd_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // effective delimiter and message limits
    always_comb begin
        if (r_dlen == 3'd0) begin
            eff_l = CW'(1);
        end else if ({1'b0, r_dlen} > 4'(DCAP)) begin
            eff_l = CW'(DCAP);
        end else begin
            eff_l = CW'(r_dlen);
        end
        m_cap = (r_maxlen > 7'(MAX_LEN)) ? CW'(MAX_LEN) : CW'(r_maxlen);
        eff_m = (m_cap < eff_l + CW'(1)) ? eff_l + CW'(1) : m_cap;
    end

    assign fill_c     = (r_fill >= CW'(MAX_LEN)) ? CW'(MAX_LEN - 1) : r_fill;
    assign fill_new   = fill_c + CW'(1);
    assign waddr      = wrap_addr({1'b0, r_sp} + (AW+1)'(fill_c));
    assign discard_sp = wrap_addr({1'b0, r_sp} + (AW+1)'(fill_new - eff_l));
    assign recent_new = (r_recent << 8) | RW'(i_data_byte);
    assign delim_ext  = RW'(r_delim);

    // one compare set per possible delimiter length; newest byte in lane 0
    always_comb begin
        for (int c = 1; c <= DCAP; c++) begin
            tail_hit[c] = 1'b1;
            for (int j = 0; j < c; j++) begin
                if (delim_ext[8*j +: 8] != recent_new[8*(c-1-j) +: 8]) begin
                    tail_hit[c] = 1'b0;
                end
            end
        end
        sel_hit = 1'b0;
        for (int c = 1; c <= DCAP; c++) begin
            if (eff_l == CW'(c)) begin
                sel_hit = tail_hit[c];
            end
        end
    end

    assign match     = sel_hit && (fill_new >= eff_l);
    assign take_byte = i_cmd.step && (i_action == tdd_pkg::ACT_DATA) && r_enable;
    assign do_clear  = i_cmd.step && (i_action == tdd_pkg::ACT_CLEAR);
    assign last_byte = (r_cnt + CW'(1)) == r_len;

    assign o_status.emit      = (i_action == tdd_pkg::ACT_DATA) && r_enable && match
                                && (fill_new > eff_l);
    assign o_status.out_free  = !r_out_valid || i_out_ready;
    assign o_status.last_byte = last_byte;

    always_comb begin
        n_sp        = r_sp;
        n_fill      = r_fill;
        n_recent    = r_recent;
        n_rd_ptr    = r_rd_ptr;
        n_len       = r_len;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (do_clear) begin
            n_sp     = '0;
            n_fill   = '0;
            n_recent = '0;
        end else if (take_byte) begin
            if (match) begin
                n_sp     = '0;
                n_fill   = '0;
                n_recent = '0;
                n_rd_ptr = r_sp;
                n_len    = fill_new;
                n_cnt    = '0;
            end else if (fill_new >= eff_m) begin
                n_sp     = discard_sp;
                n_fill   = eff_l;
                n_recent = recent_new;
            end else begin
                n_fill   = fill_new;
                n_recent = recent_new;
            end
        end
        if (i_cmd.load) begin
            n_out_valid = 1'b1;
            n_rd_ptr    = wrap_addr({1'b0, r_rd_ptr} + (AW+1)'(1));
            n_cnt       = r_cnt + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp        <= '0;
            r_fill      <= '0;
            r_recent    <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_sp        <= n_sp;
            r_fill      <= n_fill;
            r_recent    <= n_recent;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_ptr <= n_rd_ptr;
        r_len    <= n_len;
        if (i_cmd.load) begin
            r_out_byte <= rd_data;
            r_out_last <= last_byte;
            r_out_len  <= tdd_pkg::LEN_W'(r_len);
        end
    end

    // store is read at the next read pointer, so its registered data is ready for the output register
    tdd_ram #(
        .WIDTH (tdd_pkg::BYTE_W),
        .DEPTH (MAX_LEN)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (take_byte),
        .i_wr_addr (waddr),
        .i_wr_data (i_data_byte),
        .i_rd_addr (n_rd_ptr),
        .o_rd_data (rd_data)
    );

    assign o_out_valid      = r_out_valid;
    assign o_out_byte       = r_out_byte;
    assign o_last           = r_out_last;
    assign o_message_length = r_out_len;

endmodule

// File: rtl/core/tail_delimiter_deframer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tail_delimiter_deframer_core
// Splits a byte stream into messages that end in a configured delimiter.
// ----------------------------------------------------------------------------
// Input channel i_in: one beat carries an action (data byte or clear) and a
// byte. Output channel o_out: one beat per message byte, delimiter included,
// with last on the final byte and the whole message length on every beat.
// Configuration goes through a plain write port (enable, delimiter bytes,
// delimiter length, max length); the user must ensure it is written only
// while the block is idle, as the block does not enforce this. Input beats
// are taken while the controller is idle. A beat that closes a message sends
// it to streaming, one byte per cycle while the receiver is ready; input is
// held off until the last byte has gone into the output register. The rate
// while streaming is set by the single read port of the message store.
// A stalled receiver simply freezes the stream; the output register keeps
// its byte, and once the last byte is parked there new input beats are taken.
// Reset (synchronous, active low) empties the buffer, drops any pending
// output and restores register defaults; the store itself is not cleared,
// as only written entries are ever read back.
// ----------------------------------------------------------------------------
module tail_delimiter_deframer_core #(
    parameter int MAX_LEN   = 64,
    parameter int DELIM_MAX = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [tdd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tdd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    tdd_in_if.sink                         i_in,
    tdd_out_if.source                      o_out
);

    tdd_pkg::t_dp_cmd    cmd;
    tdd_pkg::t_dp_status status;
    logic                in_ready;

    // sequencing: idle (taking beats) or streaming a message out
    tdd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_status   (status),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    assign i_in.ready = in_ready;

    // buffer, delimiter compare, store and output register
    tdd_dp #(
        .MAX_LEN   (MAX_LEN),
        .DELIM_MAX (DELIM_MAX)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_action         (i_in.action),
        .i_data_byte      (i_in.data_byte),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_out_ready      (o_out.ready),
        .o_out_valid      (o_out.valid),
        .o_out_byte       (o_out.out_byte),
        .o_last           (o_out.last),
        .o_message_length (o_out.message_length)
    );

endmodule

// File: tb/tail_delimiter_deframer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tail_delimiter_deframer_core_tb
// Self-checking bench for the tail-delimiter deframer. Random byte streams,
// mostly delimiter-terminated frames, are driven under several register
// settings. A scoreboard predicts every emitted beat and checks each output
// beat field by field, in order.
// ----------------------------------------------------------------------------
module tail_delimiter_deframer_core_tb;

    localparam int MAX_LEN      = 64;
    localparam int DELIM_MAX    = 4;
    localparam int SETTLE       = 4;       // block may still be busy on a beat with no output
    localparam int TAIL_CYCLES  = 20;
    localparam int CYCLE_LIMIT  = 1000000; // ends a hung run
    localparam int RANDOM_ITEMS = 150;
    localparam int QUIET_ITEMS  = 30;      // last stretch runs with no gaps or stalls

    typedef struct packed {
        logic [tdd_pkg::BYTE_W-1:0] out_byte;
        logic                       last;
        logic [tdd_pkg::LEN_W-1:0]  message_length;
    } t_msg_beat;

    // Scoreboard: own copy of the registers and message buffer, plus the
    // queue of message beats still owed by the block.
    class deframer_scoreboard;
        logic                       en;
        logic [31:0]                delim;
        logic [2:0]                 dlen;
        logic [6:0]                 mlen;
        logic [tdd_pkg::BYTE_W-1:0] store [MAX_LEN];
        int unsigned                head;
        int unsigned                fill;
        logic [31:0]                recent;   // newest byte in lane 0
        t_msg_beat                  owed_q[$];
        int                         errors;

        function new();
            en     = 1'b1;
            delim  = '0;
            dlen   = 3'd1;
            mlen   = 7'd64;
            errors = 0;
            foreach (store[i]) store[i] = '0;
            flush_buffer();
        endfunction

        function void flush_buffer();
            head   = 0;
            fill   = 0;
            recent = '0;
        endfunction

        function void set_reg(logic [tdd_pkg::CFG_IDX_W-1:0] idx,
                              logic [tdd_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                tdd_pkg::CFG_ENABLE:    en    = val[0];
                tdd_pkg::CFG_DELIM:     delim = val;
                tdd_pkg::CFG_DELIM_LEN: dlen  = val[2:0];
                tdd_pkg::CFG_MAX_LEN:   mlen  = val[6:0];
                default: ;
            endcase
        endfunction

        // zero means one; saturate at the widest delimiter the block has
        function int unsigned delim_len();
            int unsigned l;
            l = dlen;
            if (l == 0) l = 1;
            if (l > DELIM_MAX) l = DELIM_MAX;
            if (l > MAX_LEN - 1) l = MAX_LEN - 1;
            return l;
        endfunction

        function int unsigned frame_limit(int unsigned l);
            int unsigned m;
            m = mlen;
            if (m > MAX_LEN) m = MAX_LEN;
            if (m < l + 1) m = l + 1;
            return m;
        endfunction

        function logic [tdd_pkg::BYTE_W-1:0] delim_byte(int unsigned j);
            return (j < 4) ? delim[8*j +: 8] : '0;
        endfunction

        // lane l-1 of the recent bytes holds the first delimiter byte
        function bit tail_hit(int unsigned l);
            if (fill < l) return 1'b0;
            for (int j = 0; j < l; j++) begin
                if (delim_byte(j) != recent[8*(l-1-j) +: 8]) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_beat(logic act, logic [tdd_pkg::BYTE_W-1:0] b);
            int unsigned l;
            int unsigned m;
            int unsigned n;
            t_msg_beat   e;
            if (act == tdd_pkg::ACT_CLEAR) begin
                flush_buffer();
                return;
            end
            if (!en) return;
            l = delim_len();
            m = frame_limit(l);
            if (fill >= MAX_LEN) fill = MAX_LEN - 1;
            store[(head + fill) % MAX_LEN] = b;
            fill++;
            recent = {recent[23:0], b};
            if (tail_hit(l)) begin
                // delimiter on its own is dropped silently
                if (fill > l) begin
                    n = fill;
                    for (int k = 0; k < n; k++) begin
                        e.out_byte       = store[(head + k) % MAX_LEN];
                        e.last           = (k + 1 == n);
                        e.message_length = tdd_pkg::LEN_W'(n);
                        owed_q.push_back(e);
                    end
                end
                flush_buffer();
                return;
            end
            // overflow: keep only the newest delimiter-length bytes
            if (fill >= m) begin
                head = (head + fill - l) % MAX_LEN;
                fill = l;
            end
        endfunction

        function void check_beat(t_msg_beat got);
            t_msg_beat want;
            if (owed_q.size() == 0) begin
                $error("unexpected beat: out_byte %0h last %0b message_length %0d",
                       got.out_byte, got.last, got.message_length);
                errors++;
                return;
            end
            want = owed_q.pop_front();
            if (got.out_byte !== want.out_byte) begin
                $error("out_byte: expected %0h, actual %0h", want.out_byte, got.out_byte);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0b, actual %0b", want.last, got.last);
                errors++;
            end
            if (got.message_length !== want.message_length) begin
                $error("message_length: expected %0d, actual %0d",
                       want.message_length, got.message_length);
                errors++;
            end
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_wr_en;
    logic [tdd_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [tdd_pkg::CFG_DATA_W-1:0] i_cfg_data;

    tdd_in_if  in_if ();
    tdd_out_if out_if ();

    deframer_scoreboard sb = new();

    bit          gaps_on;
    bit          stalls_on;
    bit          quiet;       // set for the final stretch: no gaps, no stalls
    int unsigned fed_items;   // beats taken that the block did not simply ignore

    tail_delimiter_deframer_core #(
        .MAX_LEN   (MAX_LEN),
        .DELIM_MAX (DELIM_MAX)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Output side: every beat taken is checked against the oldest owed beat.
    // Values read here are the ones from before the edge.
    always @(posedge i_clk) begin : out_monitor
        t_msg_beat got;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.out_byte       = out_if.out_byte;
            got.last           = out_if.last;
            got.message_length = out_if.message_length;
            sb.check_beat(got);
        end
    end

    // Receiver stalls in random bursts; off in the quiet stretch.
    initial begin : rx_stalls
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stalls_on && !quiet && $urandom_range(0, 4) == 0) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tail_delimiter_deframer_core_tb NOT OK");
        $finish;
    end

    // One input beat. Valid is left high after the handshake so that the next
    // beat can follow back to back; drop it via a gap or wait_idle.
    task automatic send_beat(input logic act, input logic [tdd_pkg::BYTE_W-1:0] b);
        if (gaps_on && !quiet && $urandom_range(0, 3) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.action    <= act;
        in_if.data_byte <= b;
        do @(posedge i_clk); while (!in_if.ready);
        if (act == tdd_pkg::ACT_CLEAR || sb.en) fed_items++;
        sb.note_beat(act, b);
    endtask

    // Sender holds off until every owed beat has arrived, then lets the
    // block finish any beat that produced nothing.
    task automatic wait_idle();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [tdd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tdd_pkg::CFG_DATA_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    // only called with the block idle
    task automatic program_regs(input logic en, input logic [31:0] delim,
                                input logic [2:0] dlen, input logic [6:0] mlen);
        write_reg(tdd_pkg::CFG_ENABLE, tdd_pkg::CFG_DATA_W'(en));
        write_reg(tdd_pkg::CFG_DELIM, delim);
        write_reg(tdd_pkg::CFG_DELIM_LEN, tdd_pkg::CFG_DATA_W'(dlen));
        write_reg(tdd_pkg::CFG_MAX_LEN, tdd_pkg::CFG_DATA_W'(mlen));
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_delimiter(input int unsigned count);
        for (int j = 0; j < count; j++) send_beat(tdd_pkg::ACT_DATA, sb.delim_byte(j));
    endtask

    task automatic send_frame(input int unsigned body);
        repeat (body) send_beat(tdd_pkg::ACT_DATA, tdd_pkg::BYTE_W'($urandom));
        send_delimiter(sb.delim_len());
    endtask

    // Mostly well-formed frames; the rest is half delimiters, noise and clears.
    task automatic send_sequence();
        int unsigned kind;
        int unsigned l;
        int unsigned room;
        kind = $urandom_range(0, 11);
        l    = sb.delim_len();
        room = sb.frame_limit(l) - l;
        if (kind <= 6) begin
            send_frame($urandom_range(0, (room < 6) ? room : 6));
        end else if (kind == 7) begin
            // clean start, then a body that fills the frame to the limit or near it
            send_beat(tdd_pkg::ACT_CLEAR, tdd_pkg::BYTE_W'($urandom));
            send_frame($urandom_range(room > 4 ? room - 4 : 0, room));
        end else if (kind == 8) begin
            send_delimiter(l - 1);
            send_beat(tdd_pkg::ACT_DATA, tdd_pkg::BYTE_W'($urandom));
        end else if (kind <= 10) begin
            repeat ($urandom_range(1, 3))
                send_beat(tdd_pkg::ACT_DATA, tdd_pkg::BYTE_W'($urandom));
        end else begin
            send_beat(tdd_pkg::ACT_CLEAR, tdd_pkg::BYTE_W'($urandom));
        end
    endtask

    initial begin : stimulus
        int unsigned phase;
        int unsigned target;
        int unsigned base;

        i_rst_n         <= 1'b0;
        i_cfg_wr_en     <= 1'b0;
        i_cfg_index     <= tdd_pkg::CFG_ENABLE;
        i_cfg_data      <= '0;
        in_if.valid     <= 1'b0;
        in_if.action    <= tdd_pkg::ACT_DATA;
        in_if.data_byte <= '0;
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        quiet     = 1'b0;
        fed_items = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed ---
        // reset settings: single zero delimiter, max length 64
        send_beat(tdd_pkg::ACT_DATA, 8'hFF);
        send_beat(tdd_pkg::ACT_DATA, 8'h00);     // two-byte message
        send_beat(tdd_pkg::ACT_DATA, 8'h00);     // bare delimiter, dropped
        send_beat(tdd_pkg::ACT_DATA, 8'hA5);
        send_beat(tdd_pkg::ACT_CLEAR, 8'h5A);    // clear throws away the buffered byte
        send_beat(tdd_pkg::ACT_DATA, 8'h00);     // so this is a bare delimiter again
        wait_idle();

        // CR LF delimiter; first expected byte sits in lane 0
        program_regs(1'b1, 32'h0000_0A0D, 3'd2, 7'd64);
        send_beat(tdd_pkg::ACT_DATA, 8'h41);
        send_beat(tdd_pkg::ACT_DATA, 8'h0D);
        send_beat(tdd_pkg::ACT_DATA, 8'h0A);
        send_beat(tdd_pkg::ACT_DATA, 8'h0A);     // one byte: too short to match
        send_beat(tdd_pkg::ACT_DATA, 8'h0D);
        send_beat(tdd_pkg::ACT_DATA, 8'h0A);
        for (int i = 0; i < 5; i++) send_beat(tdd_pkg::ACT_DATA, tdd_pkg::BYTE_W'(8'h11 + i));
        wait_idle();

        // max length lowered under the fill: next byte discards, then a match
        // exactly at the limit still comes out
        program_regs(1'b1, 32'h0000_0A0D, 3'd2, 7'd3);
        send_beat(tdd_pkg::ACT_DATA, 8'h16);
        send_beat(tdd_pkg::ACT_DATA, 8'h0D);
        send_beat(tdd_pkg::ACT_DATA, 8'h0A);
        wait_idle();

        // disabled: data ignored, clear still honoured
        program_regs(1'b0, 32'h0000_0A0D, 3'd2, 7'd64);
        send_beat(tdd_pkg::ACT_DATA, 8'h0D);
        send_beat(tdd_pkg::ACT_DATA, 8'h0A);
        send_beat(tdd_pkg::ACT_CLEAR, 8'hC3);
        wait_idle();

        // delimiter length above the widest (saturates), max length above 64
        program_regs(1'b1, 32'hFFFF_FFFF, 3'd7, 7'd127);
        send_beat(tdd_pkg::ACT_DATA, 8'h00);
        repeat (4) send_beat(tdd_pkg::ACT_DATA, 8'hFF);
        wait_idle();

        // --- random ---
        base  = fed_items;
        phase = 0;
        while (fed_items - base < RANDOM_ITEMS) begin
            wait_idle();
            gaps_on   = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            if (fed_items - base >= RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
            case (phase)
                0: begin
                    // longest message: full 64 bytes ending in a 4-byte delimiter
                    program_regs(1'b1, $urandom, 3'd4, 7'd64);
                    send_beat(tdd_pkg::ACT_CLEAR, tdd_pkg::BYTE_W'($urandom));
                    send_frame(MAX_LEN - 4);
                end
                1: program_regs(1'b1, $urandom, 3'd1, 7'd2);
                2: program_regs(1'b1, $urandom, 3'd0, 7'd0);
                3: program_regs(1'b1, $urandom, 3'd7, 7'd127);
                4: begin
                    program_regs(1'b0, $urandom, 3'($urandom_range(1, 4)), 7'd16);
                    repeat (8) send_beat(logic'($urandom_range(0, 3) == 0),
                                         tdd_pkg::BYTE_W'($urandom));
                end
                default: begin
                    if ($urandom_range(0, 1) == 0)
                        program_regs(1'b1, $urandom, 3'($urandom), 7'($urandom_range(2, 12)));
                    else
                        program_regs(1'b1, $urandom, 3'($urandom), 7'($urandom));
                end
            endcase
            if (phase != 4) begin
                target = fed_items + $urandom_range(15, 30);
                while (fed_items < target) send_sequence();
            end
            phase++;
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("tail_delimiter_deframer_core_tb OK");
        else
            $display("tail_delimiter_deframer_core_tb NOT OK");
        $finish;
    end

endmodule
